// ===== src/ppq_pkg.sv =====
// Shared widths, codes, types and helpers of the plane point query unit.
package ppq_pkg;

  localparam int unsigned CW      = 32;          // Q16.16 word
  localparam int unsigned FRAC    = 16;          // fraction bits
  localparam int unsigned MW      = 48;          // magnitude of s, q, e
  localparam int unsigned SW      = MW + 2;      // signed sums
  localparam int unsigned HW      = MW / 2;      // split of |s| for products
  localparam int unsigned PPW     = CW + HW;     // partial product
  localparam int unsigned NW      = CW + MW;     // full dividend
  localparam int unsigned QW      = 41;          // quotient bits kept
  localparam int unsigned RW      = QW + 3;      // signed result before saturation
  localparam int unsigned DIV_LAT = QW + 3;      // divider register depth
  localparam int unsigned IW      = 3;           // register index
  localparam int unsigned TW      = 31;          // tolerance

  typedef enum logic [2:0] {
    FN_DIST = 3'd0,
    FN_BOX  = 3'd1,
    FN_PROJ = 3'd2,
    FN_MIRR = 3'd3,
    FN_LINE = 3'd4
  } func_e;

  localparam logic [IW-1:0] REG_A   = 3'd0;
  localparam logic [IW-1:0] REG_B   = 3'd1;
  localparam logic [IW-1:0] REG_C   = 3'd2;
  localparam logic [IW-1:0] REG_D   = 3'd3;
  localparam logic [IW-1:0] REG_TOL = 3'd4;

  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] d;
    logic [TW-1:0]        tol;
  } ppq_cfg_t;

  typedef struct packed {
    logic                 vld;
    logic [CW-1:0]        dres;
    logic                 hit;
    logic                 copl;
    logic                 degen;
    logic                 use_div;
    logic                 mirror;
    logic [2:0]           neg;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] pz;
  } ppq_side_t;

  typedef struct packed {
    logic [PPW-1:0] plo;
    logic [PPW-1:0] phi;
    logic [MW-1:0]  den;
  } ppq_divop_t;

  function automatic logic [CW-1:0] sat32(input logic signed [SW-1:0] v);
    logic [CW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[CW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/ppq_eval.sv =====
// Front pipeline: products, plane sums, flags and dividend partial products.
module ppq_eval (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       in_valid_i,
  input  logic [2:0]                 func_i,
  input  logic signed [ppq_pkg::CW-1:0] px_i,
  input  logic signed [ppq_pkg::CW-1:0] py_i,
  input  logic signed [ppq_pkg::CW-1:0] pz_i,
  input  logic signed [ppq_pkg::CW-1:0] qx_i,
  input  logic signed [ppq_pkg::CW-1:0] qy_i,
  input  logic signed [ppq_pkg::CW-1:0] qz_i,
  input  ppq_pkg::ppq_cfg_t          cfg_i,
  output ppq_pkg::ppq_side_t         side_o,
  output ppq_pkg::ppq_divop_t [2:0]  op_o
);

  localparam int unsigned CW  = ppq_pkg::CW;
  localparam int unsigned SW  = ppq_pkg::SW;
  localparam int unsigned MW  = ppq_pkg::MW;
  localparam int unsigned HW  = ppq_pkg::HW;
  localparam int unsigned PW  = 2 * CW;

  function automatic logic signed [SW-1:0] mq(input logic signed [PW-1:0] x);
    return SW'($signed(x[PW-1:ppq_pkg::FRAC]));
  endfunction

  logic signed [CW-1:0] cv [3];
  logic signed [CW-1:0] pv [3];
  logic signed [CW-1:0] qv [3];

  // stage 1
  logic                 v1_q;
  ppq_pkg::func_e       f1_q;
  logic signed [CW-1:0] p1_q [3];
  logic signed [CW-1:0] q1_q [3];
  logic signed [PW-1:0] pp_d [3], pp1_q [3];
  logic signed [PW-1:0] pq_d [3], pq1_q [3];
  logic signed [PW-1:0] cc_d [3], cc1_q [3];

  // stage 2
  logic                 v2_q;
  ppq_pkg::func_e       f2_q;
  logic signed [CW-1:0] p2_q [3];
  logic signed [CW-1:0] q2_q [3];
  logic signed [SW-1:0] s_d, s2_q, den_d, den2_q, mn, mx, qq, ee;
  logic signed [SW-1:0] tp [3];
  logic signed [SW-1:0] tq [3];
  logic                 box_d, box2_q;

  // stage 3
  ppq_pkg::ppq_side_t   side3_d, side3_q;
  logic signed [SW-1:0] sa, da;
  logic [MW-1:0]        ms_d, ms3_q, md_d, md3_q;
  logic signed [CW-1:0] csel [3];
  logic signed [CW:0]   cext [3];
  logic [CW-1:0]        mc_d [3], mc3_q [3];
  logic                 dz;

  // stage 4
  ppq_pkg::ppq_side_t   side4_q;
  ppq_pkg::ppq_divop_t [2:0] op_d, op4_q;

  always_comb begin
    cv[0] = cfg_i.a; cv[1] = cfg_i.b; cv[2] = cfg_i.c;
    pv[0] = px_i;    pv[1] = py_i;    pv[2] = pz_i;
    qv[0] = qx_i;    qv[1] = qy_i;    qv[2] = qz_i;
    for (int i = 0; i < 3; i++) begin
      pp_d[i] = cv[i] * pv[i];
      pq_d[i] = cv[i] * qv[i];
      cc_d[i] = cv[i] * cv[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tp[i] = mq(pp1_q[i]);
      tq[i] = mq(pq1_q[i]);
    end
    s_d = tp[0] + tp[1] + tp[2] + SW'(cfg_i.d);
    qq  = mq(cc1_q[0]) + mq(cc1_q[1]) + mq(cc1_q[2]);
    ee  = tq[0] + tq[1] + tq[2];
    mn  = SW'(cfg_i.d);
    mx  = SW'(cfg_i.d);
    for (int i = 0; i < 3; i++) begin
      mn = mn + ((tp[i] < tq[i]) ? tp[i] : tq[i]);
      mx = mx + ((tp[i] < tq[i]) ? tq[i] : tp[i]);
    end
    box_d = (mn[SW-1] || (mn == '0)) && !mx[SW-1];
    den_d = (f1_q == ppq_pkg::FN_LINE) ? ee : qq;
  end

  always_comb begin
    sa   = s2_q[SW-1] ? -s2_q : s2_q;
    da   = den2_q[SW-1] ? -den2_q : den2_q;
    ms_d = sa[MW-1:0];
    md_d = da[MW-1:0];
    dz   = (den2_q == '0);
    for (int i = 0; i < 3; i++) begin
      csel[i] = (f2_q == ppq_pkg::FN_LINE) ? q2_q[i] :
                ((i == 0) ? cfg_i.a : ((i == 1) ? cfg_i.b : cfg_i.c));
      cext[i] = (CW + 1)'(csel[i]);
      cext[i] = cext[i][CW] ? -cext[i] : cext[i];
      mc_d[i] = cext[i][CW-1:0];
      side3_d.neg[i] = csel[i][CW-1] ^ s2_q[SW-1] ^ den2_q[SW-1];
    end
    side3_d.vld     = v2_q;
    side3_d.dres    = (f2_q == ppq_pkg::FN_DIST) ? ppq_pkg::sat32(s2_q) : '0;
    side3_d.hit     = (f2_q == ppq_pkg::FN_BOX) ? box2_q : ((f2_q == ppq_pkg::FN_LINE) && dz);
    side3_d.copl    = (f2_q == ppq_pkg::FN_LINE) && dz && (ms_d <= MW'(cfg_i.tol));
    side3_d.degen   = ((f2_q == ppq_pkg::FN_PROJ) || (f2_q == ppq_pkg::FN_MIRR)) && dz;
    side3_d.use_div = ((f2_q == ppq_pkg::FN_PROJ) || (f2_q == ppq_pkg::FN_MIRR) ||
                       (f2_q == ppq_pkg::FN_LINE)) && !dz;
    side3_d.mirror  = (f2_q == ppq_pkg::FN_MIRR);
    side3_d.px      = p2_q[0];
    side3_d.py      = p2_q[1];
    side3_d.pz      = p2_q[2];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      op_d[i].plo = mc3_q[i] * ms3_q[HW-1:0];
      op_d[i].phi = mc3_q[i] * ms3_q[MW-1:HW];
      op_d[i].den = md3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      side3_q <= '0;
      side4_q <= '0;
    end else if (en_i) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      side3_q <= side3_d;
      side4_q <= side3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_q   <= ppq_pkg::func_e'(func_i);
      f2_q   <= f1_q;
      s2_q   <= s_d;
      den2_q <= den_d;
      box2_q <= box_d;
      ms3_q  <= ms_d;
      md3_q  <= md_d;
      op4_q  <= op_d;
      for (int i = 0; i < 3; i++) begin
        p1_q[i]  <= pv[i];
        q1_q[i]  <= qv[i];
        pp1_q[i] <= pp_d[i];
        pq1_q[i] <= pq_d[i];
        cc1_q[i] <= cc_d[i];
        p2_q[i]  <= p1_q[i];
        q2_q[i]  <= q1_q[i];
        mc3_q[i] <= mc_d[i];
      end
    end
  end

  assign side_o = side4_q;
  assign op_o   = op4_q;

endmodule

// ===== src/ppq_div.sv =====
// Pipelined restoring divider lane, one quotient bit per stage, clamped to 2^40.
module ppq_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  ppq_pkg::ppq_divop_t        op_i,
  output logic [ppq_pkg::QW-1:0]     quo_o
);

  localparam int unsigned MW = ppq_pkg::MW;
  localparam int unsigned NW = ppq_pkg::NW;
  localparam int unsigned QW = ppq_pkg::QW;
  localparam int unsigned HW = ppq_pkg::HW;

  logic [NW-1:0] n_d, n_q;
  logic [MW-1:0] dn_q;

  logic [MW-1:0] rem_d [QW+1];
  logic [MW-1:0] rem_q [QW+1];
  logic [QW-1:0] acc_d [QW+1];
  logic [QW-1:0] acc_q [QW+1];
  logic [MW-1:0] dv_d  [QW+1];
  logic [MW-1:0] dv_q  [QW+1];
  logic          ov_d  [QW+1];
  logic          ov_q  [QW+1];
  logic [MW:0]   t     [QW];
  logic          ge    [QW];

  logic [QW-1:0] res_d, res_q;
  logic          clamp;

  assign n_d = NW'(op_i.plo) + (NW'(op_i.phi) << HW);

  always_comb begin
    rem_d[0] = MW'(n_q[NW-1:QW]);
    acc_d[0] = n_q[QW-1:0];
    dv_d[0]  = dn_q;
    ov_d[0]  = (MW'(n_q[NW-1:QW]) >= dn_q);
    for (int k = 0; k < QW; k++) begin
      t[k]         = {rem_q[k], acc_q[k][QW-1]};
      ge[k]        = (t[k] >= {1'b0, dv_q[k]});
      rem_d[k+1]   = ge[k] ? MW'(t[k] - {1'b0, dv_q[k]}) : t[k][MW-1:0];
      acc_d[k+1]   = {acc_q[k][QW-2:0], ge[k]};
      dv_d[k+1]    = dv_q[k];
      ov_d[k+1]    = ov_q[k];
    end
    clamp = ov_q[QW] || (acc_q[QW][QW-1] && (|acc_q[QW][QW-2:0]));
    res_d = clamp ? {1'b1, {(QW-1){1'b0}}} : acc_q[QW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q   <= n_d;
      dn_q  <= op_i.den;
      res_q <= res_d;
      for (int k = 0; k <= QW; k++) begin
        rem_q[k] <= rem_d[k];
        acc_q[k] <= acc_d[k];
        dv_q[k]  <= dv_d[k];
        ov_q[k]  <= ov_d[k];
      end
    end
  end

  assign quo_o = res_q;

endmodule

// ===== src/plane_point_query_unit_core.sv =====
// Top level of the plane point query unit: registers, pipeline and output stage.
//
//  channel  | direction | handshake              | payload
//  cfg      | in        | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//  in       | in        | in_valid_i/in_ready_o  | func_i, px..pz_i, qx..qz_i
//  out      | out       | out_valid_o/out_ready_i| dist_res_o, flags, rx..rz_o
//
// One beat per cycle while the output is not stalled; four front stages, 44 divider stages
// (one quotient bit per iteration stage) and the output register.
// Reset clears the registers to the plane 0 with tolerance 1 and empties the pipe.
// The whole pipe holds while a result waits; cfg is always ready.
module plane_point_query_unit_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ppq_pkg::IW-1:0]        cfg_index_i,
  input  logic [ppq_pkg::CW-1:0]        cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    func_i,
  input  logic signed [ppq_pkg::CW-1:0] px_i,
  input  logic signed [ppq_pkg::CW-1:0] py_i,
  input  logic signed [ppq_pkg::CW-1:0] pz_i,
  input  logic signed [ppq_pkg::CW-1:0] qx_i,
  input  logic signed [ppq_pkg::CW-1:0] qy_i,
  input  logic signed [ppq_pkg::CW-1:0] qz_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [ppq_pkg::CW-1:0] dist_res_o,
  output logic                          hit_o,
  output logic                          coplanar_o,
  output logic                          degenerate_o,
  output logic signed [ppq_pkg::CW-1:0] rx_o,
  output logic signed [ppq_pkg::CW-1:0] ry_o,
  output logic signed [ppq_pkg::CW-1:0] rz_o
);

  localparam int unsigned CW  = ppq_pkg::CW;
  localparam int unsigned QW  = ppq_pkg::QW;
  localparam int unsigned RW  = ppq_pkg::RW;
  localparam int unsigned SW  = ppq_pkg::SW;
  localparam int unsigned LAT = ppq_pkg::DIV_LAT;

  ppq_pkg::ppq_cfg_t          cfg_q;
  ppq_pkg::ppq_side_t         side;
  ppq_pkg::ppq_side_t         sb_q [LAT];
  ppq_pkg::ppq_side_t         sb_last;
  ppq_pkg::ppq_divop_t [2:0]  op;
  logic [QW-1:0]              quo [3];
  logic                       adv;

  logic signed [CW-1:0]       pv [3];
  logic [QW:0]                tt [3];
  logic signed [RW-1:0]       r  [3];
  logic [CW-1:0]              rs_d [3];

  logic                       out_valid_q;
  logic [CW-1:0]              dist_q, rx_q, ry_q, rz_q;
  logic                       hit_q, copl_q, degen_q;

  assign adv         = !out_valid_q || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a   <= '0;
      cfg_q.b   <= '0;
      cfg_q.c   <= '0;
      cfg_q.d   <= '0;
      cfg_q.tol <= ppq_pkg::TW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ppq_pkg::REG_A:   cfg_q.a   <= cfg_data_i;
        ppq_pkg::REG_B:   cfg_q.b   <= cfg_data_i;
        ppq_pkg::REG_C:   cfg_q.c   <= cfg_data_i;
        ppq_pkg::REG_D:   cfg_q.d   <= cfg_data_i;
        ppq_pkg::REG_TOL: cfg_q.tol <= cfg_data_i[ppq_pkg::TW-1:0];
        default: ;
      endcase
    end
  end

  ppq_eval u_eval (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .px_i       (px_i),
    .py_i       (py_i),
    .pz_i       (pz_i),
    .qx_i       (qx_i),
    .qy_i       (qy_i),
    .qz_i       (qz_i),
    .cfg_i      (cfg_q),
    .side_o     (side),
    .op_o       (op)
  );

  for (genvar g = 0; g < 3; g++) begin : g_lane
    ppq_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .op_i  (op[g]),
      .quo_o (quo[g])
    );
  end

  // sideband rides alongside the divider lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) sb_q[k] <= '0;
    end else if (adv) begin
      sb_q[0] <= side;
      for (int k = 1; k < LAT; k++) sb_q[k] <= sb_q[k-1];
    end
  end

  assign sb_last = sb_q[LAT-1];

  always_comb begin
    pv[0] = sb_last.px;
    pv[1] = sb_last.py;
    pv[2] = sb_last.pz;
    for (int i = 0; i < 3; i++) begin
      tt[i]   = sb_last.mirror ? {quo[i], 1'b0} : {1'b0, quo[i]};
      r[i]    = RW'(pv[i]) + (sb_last.neg[i] ? RW'(tt[i]) : -RW'(tt[i]));
      rs_d[i] = sb_last.use_div ? ppq_pkg::sat32(SW'(r[i])) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sb_last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q  <= sb_last.dres;
      hit_q   <= sb_last.hit;
      copl_q  <= sb_last.copl;
      degen_q <= sb_last.degen;
      rx_q    <= rs_d[0];
      ry_q    <= rs_d[1];
      rz_q    <= rs_d[2];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dist_res_o   = dist_q;
  assign hit_o        = hit_q;
  assign coplanar_o   = copl_q;
  assign degenerate_o = degen_q;
  assign rx_o         = rx_q;
  assign ry_o         = ry_q;
  assign rz_o         = rz_q;

endmodule

// ===== src/ppq_chk.sv =====
// Port-level checks for the plane point query unit, bound to the top level.
module ppq_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [ppq_pkg::CW-1:0] dist_res_o,
  input logic                          hit_o,
  input logic                          coplanar_o,
  input logic                          degenerate_o,
  input logic signed [ppq_pkg::CW-1:0] rx_o,
  input logic signed [ppq_pkg::CW-1:0] ry_o,
  input logic signed [ppq_pkg::CW-1:0] rz_o
);

  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rx_o) && $stable(ry_o) &&
    $stable(rz_o) && $stable(dist_res_o))
    else $error("stalled result changed");

  a_copl_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && coplanar_o |-> hit_o)
    else $error("coplanar without parallel");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> (rx_o == 0) && (ry_o == 0) && (rz_o == 0) &&
    (dist_res_o == 0) && !hit_o)
    else $error("degenerate result not zero");

endmodule

bind plane_point_query_unit_core ppq_chk u_ppq_chk (.*);
